// ===== sv/lpht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear probing hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int KeyWidth    = 16;
   localparam int OpWidth     = 3;
   localparam int SlotWidth   = 4;
   localparam int StatusWidth = 2;
   localparam int ProbeWidth  = 4;
   localparam int TotalWidth  = 8;
   localparam int OccWidth    = 4;

   localparam logic [OpWidth-1:0] OP_INSERT = 3'd0;
   localparam logic [OpWidth-1:0] OP_LOOKUP = 3'd1;
   localparam logic [OpWidth-1:0] OP_DELETE = 3'd2;
   localparam logic [OpWidth-1:0] OP_STATS  = 3'd3;
   localparam logic [OpWidth-1:0] OP_READ   = 3'd4;

   localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_FULL      = 2'd2;
   localparam logic [StatusWidth-1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH1,
      ST_HASH2,
      ST_HASH3,
      ST_PROBE,
      ST_SLOT_RD,
      ST_SLOT_EV
   } state_type;

   typedef struct packed {
      logic                  used;
      logic [ProbeWidth-1:0] probes;
      logic [KeyWidth-1:0]   key;
   } entry_type;

endpackage : lpht_pkg
`default_nettype wire

// ===== sv/linear_probe_hash_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing, held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Statistics queries, unused codes and out-of-range slots give the result strobe
// in the cycle after the accepting edge, and a new beat may follow at once.
// Delete and read pass through the slot read and evaluate states before the strobe,
// and a new beat may follow once it shows. Insert and lookup pass through the hash
// states, then read one RAM slot per probed slot, for 1 to TABLE_SIZE probes.
// After reset a clearing pass over every slot keeps busy high.
module linear_probe_hash_table_core
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = 13
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [OpWidth-1:0]     req_operation,
   input  wire logic [KeyWidth-1:0]    req_search_key,
   input  wire logic [SlotWidth-1:0]   req_slot_index,
   output logic                        rsp_valid,
   output logic [StatusWidth-1:0]      rsp_status,
   output logic [SlotWidth-1:0]        rsp_found_slot,
   output logic [KeyWidth-1:0]         rsp_slot_key,
   output logic [ProbeWidth-1:0]       rsp_probe_count,
   output logic [TotalWidth-1:0]       rsp_total_probes,
   output logic [OccWidth-1:0]         rsp_occupied_count
);

   localparam int IdxW = $clog2(TABLE_SIZE);
   localparam int CntW = $clog2(TABLE_SIZE + 1);
   localparam int SumW = $clog2(15 * TABLE_SIZE + 1);
   localparam logic [31:0] Recip = 32'((64'd1 << 32) / TABLE_SIZE);
   localparam logic [IdxW-1:0] LastSlot = IdxW'(TABLE_SIZE - 1);

   entry_type mem [TABLE_SIZE];
   entry_type rd_data_ff;
   logic [IdxW-1:0] rd_addr;
   logic mem_we;
   logic [IdxW-1:0] mem_wa;
   entry_type mem_wd;

   state_type state_ff, state_in;
   logic [OpWidth-1:0] op_ff, op_in;
   logic [KeyWidth-1:0] key_ff, key_in;
   logic [SlotWidth-1:0] idx_ff, idx_in;
   logic [KeyWidth-1:0] quot_ff, quot_in;
   logic [IdxW:0] rem_ff, rem_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic [CntW-1:0] n_ff, n_in;
   logic [IdxW-1:0] clr_ff, clr_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [CntW-1:0] used_ff, used_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [SlotWidth-1:0] rsp_slot_ff, rsp_slot_in;
   logic [KeyWidth-1:0] rsp_key_ff, rsp_key_in;
   logic [ProbeWidth-1:0] rsp_probe_ff, rsp_probe_in;
   logic [TotalWidth-1:0] rsp_total_ff, rsp_total_in;
   logic [OccWidth-1:0] rsp_occ_ff, rsp_occ_in;

   logic [IdxW-1:0] home_pos;
   logic [IdxW-1:0] next_pos;
   logic [IdxW-1:0] slot_addr;
   logic [ProbeWidth-1:0] insert_pc;
   logic [47:0] hash_prod;

   assign hash_prod = 48'(key_ff) * 48'(Recip);
   assign home_pos  = (32'(rem_ff) >= 32'(TABLE_SIZE)) ?
                      IdxW'(32'(rem_ff) - 32'(TABLE_SIZE)) : IdxW'(rem_ff);
   assign next_pos  = (pos_ff == LastSlot) ? '0 : pos_ff + IdxW'(1);
   assign slot_addr = IdxW'(idx_ff);
   assign insert_pc = (32'(n_ff) > 32'd15) ? 4'd15 : ProbeWidth'(n_ff);

   always_comb begin
      unique case (state_ff)
         ST_HASH3: rd_addr = home_pos;
         ST_PROBE: rd_addr = next_pos;
         default:  rd_addr = slot_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sum_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sum_ff       <= sum_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_probe_ff  <= rsp_probe_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      sum_in        = sum_ff;
      used_in       = used_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_probe_in  = rsp_probe_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_wa        = pos_ff;
      mem_wd        = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + IdxW'(1);
            if (clr_ff == LastSlot) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in  = req_operation;
               key_in = req_search_key;
               idx_in = req_slot_index;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = '0;
               rsp_key_in    = '0;
               rsp_probe_in  = '0;
               rsp_total_in  = '0;
               rsp_occ_in    = '0;
               unique case (req_operation)
                  OP_INSERT, OP_LOOKUP: begin
                     state_in = ST_HASH1;
                  end
                  OP_DELETE, OP_READ: begin
                     if (32'(req_slot_index) >= 32'(TABLE_SIZE)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_slot_in   = req_slot_index;
                     end else begin
                        state_in = ST_SLOT_RD;
                     end
                  end
                  OP_STATS: begin
                     rsp_valid_in = 1'b1;
                     rsp_total_in = (32'(sum_ff) > 32'd255) ? 8'd255 : TotalWidth'(sum_ff);
                     rsp_occ_in   = (32'(used_ff) > 32'd15) ? 4'd15 : OccWidth'(used_ff);
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
               endcase
            end
         end
         ST_HASH1: begin
            quot_in  = hash_prod[47:32];
            state_in = ST_HASH2;
         end
         ST_HASH2: begin
            rem_in   = (IdxW + 1)'(32'(key_ff) - 32'(quot_ff) * 32'(TABLE_SIZE));
            state_in = ST_HASH3;
         end
         ST_HASH3: begin
            pos_in   = home_pos;
            n_in     = CntW'(1);
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            pos_in = next_pos;
            n_in   = n_ff + CntW'(1);
            if (op_ff == OP_INSERT) begin
               if (!rd_data_ff.used) begin
                  mem_we        = 1'b1;
                  mem_wa        = pos_ff;
                  mem_wd.used   = 1'b1;
                  mem_wd.probes = insert_pc;
                  mem_wd.key    = key_ff;
                  sum_in        = sum_ff + SumW'(insert_pc);
                  used_in       = used_ff + CntW'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = SlotWidth'(pos_ff);
                  rsp_key_in    = key_ff;
                  rsp_probe_in  = insert_pc;
                  state_in      = ST_IDLE;
               end else if (n_ff == CntW'(TABLE_SIZE)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FULL;
                  state_in      = ST_IDLE;
               end
            end else begin
               if (!rd_data_ff.used) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_FOUND;
                  state_in      = ST_IDLE;
               end else if (rd_data_ff.key == key_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = SlotWidth'(pos_ff);
                  rsp_key_in    = key_ff;
                  rsp_probe_in  = rd_data_ff.probes;
                  state_in      = ST_IDLE;
               end else if (n_ff == CntW'(TABLE_SIZE)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_FOUND;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_SLOT_RD: begin
            state_in = ST_SLOT_EV;
         end
         ST_SLOT_EV: begin
            rsp_valid_in = 1'b1;
            rsp_slot_in  = idx_ff;
            state_in     = ST_IDLE;
            if (!rd_data_ff.used) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_key_in   = rd_data_ff.key;
               rsp_probe_in = rd_data_ff.probes;
               if (op_ff == OP_DELETE) begin
                  mem_we  = 1'b1;
                  mem_wa  = slot_addr;
                  sum_in  = sum_ff - SumW'(rd_data_ff.probes);
                  used_in = used_ff - CntW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_slot     = rsp_slot_ff;
   assign rsp_slot_key       = rsp_key_ff;
   assign rsp_probe_count    = rsp_probe_ff;
   assign rsp_total_probes   = rsp_total_ff;
   assign rsp_occupied_count = rsp_occ_ff;

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("Result beat shown while an operation is still running.");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start || (state_ff != ST_IDLE)))
      else $error("Result beat without a preceding request or operation.");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= 32'(TABLE_SIZE))
      else $error("Occupied count exceeds the table size.");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |->
         (n_ff != '0) && (32'(n_ff) <= 32'(TABLE_SIZE)) && (32'(pos_ff) < 32'(TABLE_SIZE)))
      else $error("Probe walk left its bounds.");

endmodule : linear_probe_hash_table_core
`default_nettype wire
